/* design/lmsf_pkg.sv */
// ----------------------------------------------------------------------------
// lmsf_pkg
// Shared widths, reset values, register indexes and control bundles of the
// LMS adaptive FIR filter.
// ----------------------------------------------------------------------------
package lmsf_pkg;

   localparam int X_W       = 16;   // Q1.15 audio sample
   localparam int COEF_W    = 24;   // Q4.20 coefficient
   localparam int COEF_FRAC = 20;
   localparam int CSR_W     = 16;   // widest register
   localparam int LIM_SHIFT = 8;    // Q4.12 limit -> Q20
   localparam int LIM_W     = CSR_W + LIM_SHIFT;
   localparam int QUOT_W    = COEF_W;
   localparam int UPD_SHIFT = 26;   // Q46 update -> Q20

   localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sh100000;
   localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
   localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
   localparam logic signed [X_W-1:0]    Y_MAX    = 16'sh7FFF;
   localparam logic signed [X_W-1:0]    Y_MIN    = 16'sh8000;

   localparam logic [CSR_W-1:0] STEP_SIZE_RESET  = 16'd655;
   localparam logic [CSR_W-1:0] NORM_LIMIT_RESET = 16'd8192;

   // register indexes
   localparam logic [0:0] CSR_STEP_SIZE  = 1'b0;
   localparam logic [0:0] CSR_NORM_LIMIT = 1'b1;

   // per-cell control: shift the delay line in, or rotate the whole row
   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctl_type;

   // rescale engine commands and status
   typedef struct packed {
      logic root_start;
      logic div_start;
   } scale_ctl_type;

   typedef struct packed {
      logic done;
   } scale_sts_type;

endpackage

/* design/lmsf_cell.sv */
// ----------------------------------------------------------------------------
// lmsf_cell
// One tap of the filter: a delay-line sample and its coefficient. Shifts the
// sample in from the newer neighbor, or rotates sample and coefficient one
// place toward the head of the row.
// ----------------------------------------------------------------------------
module lmsf_cell
   import lmsf_pkg::*;
#(
   parameter bit MID_TAP = 1'b0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctl_type             ctl,
   input  logic signed [X_W-1:0]    x_prev,
   input  logic signed [X_W-1:0]    x_next,
   input  logic signed [COEF_W-1:0] c_next,
   output logic signed [X_W-1:0]    x_out,
   output logic signed [COEF_W-1:0] c_out
);

   logic signed [X_W-1:0]    x_ff, x_in;
   logic signed [COEF_W-1:0] c_ff, c_in;

   // select shift, rotate or hold
   always_comb begin
      if (ctl.shift) begin
         x_in = x_prev;
      end else if (ctl.rotate) begin
         x_in = x_next;
      end else begin
         x_in = x_ff;
      end
      c_in = ctl.rotate ? c_next : c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         c_ff <= MID_TAP ? COEF_ONE : '0;
      end else begin
         x_ff <= x_in;
         c_ff <= c_in;
      end
   end

   assign x_out = x_ff;
   assign c_out = c_ff;

endmodule

/* design/lmsf_rescale.sv */
// ----------------------------------------------------------------------------
// lmsf_rescale
// Iterative norm rescale engine: a two-bits-per-cycle integer square root of
// the squared norm, then one restoring divide per coefficient giving
// round(|c| * limit / norm) with the sign put back.
// ----------------------------------------------------------------------------
module lmsf_rescale
   import lmsf_pkg::*;
#(
   parameter int SUMSQ_W = 52
) (
   input  logic                     clock,
   input  logic                     reset,
   input  scale_ctl_type            ctl,
   input  logic [SUMSQ_W-1:0]       sumsq,
   input  logic [LIM_W-1:0]         lim,
   input  logic signed [COEF_W-1:0] coef,
   output scale_sts_type            sts,
   output logic signed [COEF_W-1:0] quot
);

   localparam int RT_W   = (SUMSQ_W + 1) / 2;
   localparam int SQP_W  = 2 * RT_W;
   localparam int NUM_W  = COEF_W + LIM_W + 2;
   localparam int REM_A  = RT_W + 2;
   localparam int REM_B  = NUM_W - QUOT_W;
   localparam int REM_W  = (REM_A > REM_B) ? REM_A : REM_B;
   localparam int CNT_W  = $clog2(RT_W + 1);

   typedef enum logic [2:0] {
      SC_IDLE = 3'b001,
      SC_ROOT = 3'b010,
      SC_DIV  = 3'b100
   } sc_state_type;

   sc_state_type        state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SQP_W-1:0]    sq_ff, sq_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [RT_W-1:0]     root_ff, root_in;
   logic [QUOT_W-1:0]   num_ff, num_in;
   logic [QUOT_W-1:0]   q_ff, q_in;
   logic                neg_ff, neg_in;
   logic                done_ff, done_in;

   logic [REM_W-1:0]    rt_rem, rt_trial, dv_rem, dv_div;
   logic [RT_W-1:0]     nrm;
   logic [COEF_W-1:0]   mag;
   logic [COEF_W+LIM_W-1:0] mag_lim;
   logic [NUM_W-1:0]    num_full;
   logic                rt_last, dv_last;

   // root step: bring down two bits, try (root << 2) | 1
   assign rt_rem   = {rem_ff[REM_W-3:0], sq_ff[SQP_W-1 -: 2]};
   assign rt_trial = REM_W'({root_ff, 2'b01});

   // divide step: bring down one bit, try twice the norm
   assign nrm      = (root_ff == '0) ? RT_W'(1) : root_ff;
   assign dv_rem   = {rem_ff[REM_W-2:0], num_ff[QUOT_W-1]};
   assign dv_div   = REM_W'({nrm, 1'b0});

   // numerator: 2 * |c| * limit + norm
   assign mag      = coef[COEF_W-1] ? COEF_W'(-coef) : COEF_W'(coef);
   assign mag_lim  = mag * lim;
   assign num_full = NUM_W'({mag_lim, 1'b0}) + NUM_W'(nrm);

   assign rt_last  = (cnt_ff == CNT_W'(RT_W - 1));
   assign dv_last  = (cnt_ff == CNT_W'(QUOT_W - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      case (state_ff)
         SC_IDLE: begin
            if (ctl.root_start) begin
               sq_in    = SQP_W'(sumsq);
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = SC_ROOT;
            end else if (ctl.div_start) begin
               rem_in   = REM_W'(num_full[NUM_W-1:QUOT_W]);
               num_in   = num_full[QUOT_W-1:0];
               neg_in   = coef[COEF_W-1];
               q_in     = '0;
               cnt_in   = '0;
               state_in = SC_DIV;
            end
         end
         SC_ROOT: begin
            sq_in = {sq_ff[SQP_W-3:0], 2'b00};
            if (rt_rem >= rt_trial) begin
               rem_in  = rt_rem - rt_trial;
               root_in = {root_ff[RT_W-2:0], 1'b1};
            end else begin
               rem_in  = rt_rem;
               root_in = {root_ff[RT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (rt_last) begin
               done_in  = 1'b1;
               state_in = SC_IDLE;
            end
         end
         SC_DIV: begin
            num_in = {num_ff[QUOT_W-2:0], 1'b0};
            if (dv_rem >= dv_div) begin
               rem_in = dv_rem - dv_div;
               q_in   = {q_ff[QUOT_W-2:0], 1'b1};
            end else begin
               rem_in = dv_rem;
               q_in   = {q_ff[QUOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (dv_last) begin
               done_in  = 1'b1;
               state_in = SC_IDLE;
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
   end

   assign sts.done = done_ff;
   assign quot     = neg_ff ? COEF_W'(-$signed(q_ff)) : $signed(q_ff);

endmodule

/* design/lms_adaptive_fir.sv */
// ----------------------------------------------------------------------------
// lms_adaptive_fir
// LMS adaptive FIR filter with coefficient norm limit and saturated output.
// ----------------------------------------------------------------------------
// One sample at a time. The taps sit in a row of cells that rotates through
// a single multiply-accumulate at the head, so a normal beat runs a filter
// pass, an update pass and a norm pass, each one tap per cycle. When the
// norm exceeds the limit, a square root and a bit-serial divide per tap are
// added. A pass-through beat leaves the taps and coefficients untouched. The
// next beat is taken once the current one is finished; a finished result
// waits in the output register.
// ----------------------------------------------------------------------------
module lms_adaptive_fir
   import lmsf_pkg::*;
#(
   parameter int TAPS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [X_W-1:0] req_sample,
   input  logic                  req_pass_through,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [X_W-1:0] rsp_filtered,
   output logic                  rsp_saturated,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [CSR_W-1:0]      csr_data
);

   localparam int LOG_T   = $clog2(TAPS);
   localparam int IDX_W   = (LOG_T < 1) ? 1 : LOG_T;
   localparam int ACC_W   = 40 + LOG_T;
   localparam int Y_W     = ACC_W - COEF_FRAC;
   localparam int ERR_W   = Y_W + 1;
   localparam int SE_W    = ERR_W + CSR_W + 1;
   localparam int D_W     = SE_W + X_W;
   localparam int RD_W    = D_W - UPD_SHIFT;
   localparam int CN_W    = RD_W + 1;
   localparam int SUMSQ_W = 2 * COEF_W + 1 + LOG_T;
   localparam int SQ_W    = 2 * COEF_W;

   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
   localparam logic signed [D_W-1:0]   D_HALF   = D_W'(1) <<< (UPD_SHIFT - 1);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_MAC   = 12'b000000000010,
      ST_ERR   = 12'b000000000100,
      ST_STEP  = 12'b000000001000,
      ST_UPD   = 12'b000000010000,
      ST_SQ    = 12'b000000100000,
      ST_CMP   = 12'b000001000000,
      ST_ROOT  = 12'b000010000000,
      ST_LOAD  = 12'b000100000000,
      ST_DIV   = 12'b001000000000,
      ST_WRITE = 12'b010000000000,
      ST_DONE  = 12'b100000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           tap_ff, tap_in;
   logic [CSR_W-1:0]           step_ff, step_in;
   logic [CSR_W-1:0]           limit_ff, limit_in;
   logic signed [X_W-1:0]      sample_ff, sample_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [Y_W-1:0]      y_ff, y_in;
   logic signed [SE_W-1:0]     se_ff, se_in;
   logic [SUMSQ_W-1:0]         sumsq_ff, sumsq_in;
   logic [2*LIM_W-1:0]         limsq_ff, limsq_in;
   logic signed [X_W-1:0]      filt_ff, filt_in;
   logic                       sat_ff, sat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [X_W-1:0]      rsp_filt_ff, rsp_filt_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic signed [X_W-1:0]      x_q [TAPS];
   logic signed [COEF_W-1:0]   c_q [TAPS];
   logic signed [COEF_W-1:0]   c_tail;
   cell_ctl_type               cell_ctl;
   scale_ctl_type              sc_ctl;
   scale_sts_type              sc_sts;
   logic signed [COEF_W-1:0]   sc_quot;

   logic                       accept, tap_last, out_free, y_clip;
   logic [LIM_W-1:0]           lim;
   logic signed [ACC_W-1:0]    acc_rnd;
   logic signed [ERR_W-1:0]    err;
   logic signed [CSR_W:0]      step_s;
   logic signed [D_W-1:0]      d_w, d_rnd;
   logic signed [RD_W-1:0]     rd;
   logic signed [CN_W-1:0]     c_sum;
   logic signed [COEF_W-1:0]   c_new;
   logic signed [SQ_W-1:0]     c_sq;

   // row of tap cells; cell 0 is the newest sample and the head of rotation
   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      logic signed [X_W-1:0]    x_prev_w;
      logic signed [COEF_W-1:0] c_next_w;
      if (i == 0) begin : g_head
         assign x_prev_w = req_sample;
      end else begin : g_body
         assign x_prev_w = x_q[i-1];
      end
      if (i == TAPS - 1) begin : g_last
         assign c_next_w = c_tail;
      end else begin : g_mid
         assign c_next_w = c_q[i+1];
      end
      lmsf_cell #(
         .MID_TAP (i == TAPS / 2)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (cell_ctl),
         .x_prev (x_prev_w),
         .x_next (x_q[(i + 1) % TAPS]),
         .c_next (c_next_w),
         .x_out  (x_q[i]),
         .c_out  (c_q[i])
      );
   end

   lmsf_rescale #(
      .SUMSQ_W (SUMSQ_W)
   ) u_rescale (
      .clock (clock),
      .reset (reset),
      .ctl   (sc_ctl),
      .sumsq (sumsq_ff),
      .lim   (lim),
      .coef  (c_q[0]),
      .sts   (sc_sts),
      .quot  (sc_quot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign tap_last  = (tap_ff == IDX_W'(TAPS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign lim       = {limit_ff, {LIM_SHIFT{1'b0}}};

   // filter output rounding and error
   assign acc_rnd = acc_ff + ACC_HALF;
   assign err     = ERR_W'(sample_ff) - ERR_W'(y_ff);
   assign step_s  = $signed({1'b0, step_ff});
   assign y_clip  = !((&y_ff[Y_W-1:X_W-1]) || !(|y_ff[Y_W-1:X_W-1]));

   // coefficient update at the head: c + round(mu * err * x)
   assign d_w   = se_ff * x_q[0];
   assign d_rnd = d_w + D_HALF;
   assign rd    = d_rnd[D_W-1:UPD_SHIFT];
   assign c_sum = CN_W'(c_q[0]) + CN_W'(rd);
   always_comb begin
      if (c_sum > CN_W'(COEF_MAX)) begin
         c_new = COEF_MAX;
      end else if (c_sum < CN_W'(COEF_MIN)) begin
         c_new = COEF_MIN;
      end else begin
         c_new = c_sum[COEF_W-1:0];
      end
   end

   assign c_sq = c_q[0] * c_q[0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      sample_in    = sample_ff;
      acc_in       = acc_ff;
      y_in         = y_ff;
      se_in        = se_ff;
      sumsq_in     = sumsq_ff;
      limsq_in     = limsq_ff;
      filt_in      = filt_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_filt_in  = rsp_filt_ff;
      rsp_sat_in   = rsp_sat_ff;
      cell_ctl     = '0;
      sc_ctl       = '0;
      c_tail       = c_q[0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample;
               if (req_pass_through) begin
                  filt_in  = req_sample;
                  sat_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  cell_ctl.shift = 1'b1;
                  acc_in         = '0;
                  tap_in         = '0;
                  state_in       = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cell_ctl.rotate = 1'b1;
            acc_in          = acc_ff + c_q[0] * x_q[0];
            tap_in          = tap_ff + 1'b1;
            if (tap_last) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            y_in     = acc_rnd[ACC_W-1:COEF_FRAC];
            limsq_in = lim * lim;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            se_in    = step_s * err;
            sat_in   = y_clip;
            filt_in  = y_clip ? (y_ff[Y_W-1] ? Y_MIN : Y_MAX) : y_ff[X_W-1:0];
            tap_in   = '0;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cell_ctl.rotate = 1'b1;
            c_tail          = c_new;
            tap_in          = tap_ff + 1'b1;
            if (tap_last) begin
               sumsq_in = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cell_ctl.rotate = 1'b1;
            sumsq_in        = sumsq_ff + SUMSQ_W'(c_sq[SQ_W-2:0]);
            tap_in          = tap_ff + 1'b1;
            if (tap_last) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (sumsq_ff > SUMSQ_W'(limsq_ff)) begin
               sc_ctl.root_start = 1'b1;
               state_in          = ST_ROOT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ROOT: begin
            if (sc_sts.done) begin
               tap_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            sc_ctl.div_start = 1'b1;
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            if (sc_sts.done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cell_ctl.rotate = 1'b1;
            c_tail          = sc_quot;
            tap_in          = tap_ff + 1'b1;
            state_in        = tap_last ? ST_DONE : ST_LOAD;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_filt_in  = filt_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      step_in  = step_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_STEP_SIZE:  step_in  = csr_data;
            CSR_NORM_LIMIT: limit_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         step_ff      <= STEP_SIZE_RESET;
         limit_ff     <= NORM_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         step_ff      <= step_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      acc_ff      <= acc_in;
      y_ff        <= y_in;
      se_ff       <= se_in;
      sumsq_ff    <= sumsq_in;
      limsq_ff    <= limsq_in;
      filt_ff     <= filt_in;
      sat_ff      <= sat_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filt_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
